// ===== hw/rtl/icer_pkg.sv =====
// shared types and constants for the edge-replicating image convolution block
// no dependencies
package icer_pkg;

    localparam int MAX_KERNEL_SIDE = 7;
    localparam int MAX_FRAME_WIDTH = 1024;
    localparam int HEIGHT_CAP      = 1024;
    localparam int COEF_COUNT      = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;

    localparam int SIDE_W  = 3;
    localparam int DIV_W   = 15;
    localparam int SIZE_W  = 11;
    localparam int COORD_W = 10;
    localparam int PIX_W   = 16;
    localparam int IDX_W   = 6;
    localparam int SLOT_W  = 3;
    localparam int ACC_W   = 38;
    localparam int CNT_W   = 6;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIDE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd3;

    // beat kinds on s_tuser
    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic accept;
        logic setup;
        logic tap_issue;
        logic div_start;
        logic emit_adv;
    } icer_cmd_t;

    typedef struct packed {
        logic window_ok;
        logic last_tap;
        logic pipe_busy;
        logic div_busy;
        logic emit_last;
    } icer_status_t;

endpackage

// ===== hw/rtl/icer_ctrl.sv =====
// sequencing state machine for the convolution block
// depends on icer_pkg
module icer_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_kind,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output icer_pkg::icer_cmd_t  cmd,
    input  icer_pkg::icer_status_t st
);
    import icer_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_TAPS  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_EMIT);

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.accept    = s_tvalid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_kind == REQ_PIXEL) state_next = S_SETUP;
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = st.window_ok ? S_TAPS : S_IDLE;
            end
            S_TAPS: begin
                cmd.tap_issue = 1'b1;
                if (st.last_tap) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (!st.pipe_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (!st.div_busy) state_next = S_EMIT;
            end
            S_EMIT: begin
                if (m_tready) begin
                    cmd.emit_adv = 1'b1;
                    if (st.emit_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // results only go out once the sum and the quotient are settled
    a_emit_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (!st.div_busy && !st.pipe_busy))
        else $error("result shown before quotient settled");
    a_taps_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TAPS && st.last_tap) |=> (state_reg == S_DRAIN))
        else $error("tap walk did not end on last tap");
    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> st.div_busy)
        else $error("divider did not start");

endmodule

// ===== hw/rtl/icer_dp.sv =====
// datapath: config registers, line and coefficient stores, mac, divider, emit counters
// depends on icer_pkg
module icer_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [icer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [icer_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                         s_kind,
    input  logic [icer_pkg::IDX_W-1:0]   coef_index,
    input  logic signed [icer_pkg::PIX_W-1:0] coef_value,
    input  logic signed [icer_pkg::PIX_W-1:0] pixel_value,
    input  icer_pkg::icer_cmd_t          cmd,
    output icer_pkg::icer_status_t       st,
    output logic [icer_pkg::COORD_W-1:0] out_row,
    output logic [icer_pkg::COORD_W-1:0] out_col,
    output logic [icer_pkg::PIX_W-1:0]   out_value
);
    import icer_pkg::*;

    localparam int LINE_DEPTH = (1 << SLOT_W) * MAX_FRAME_WIDTH;
    localparam int LA_W       = SLOT_W + COORD_W;

    // configuration registers
    logic [SIDE_W-1:0] side_cfg_reg;
    logic [DIV_W-1:0]  div_cfg_reg;
    logic [SIZE_W-1:0] w_cfg_reg, h_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_cfg_reg <= SIDE_W'(3);
            div_cfg_reg  <= DIV_W'(1);
            w_cfg_reg    <= SIZE_W'(MAX_FRAME_WIDTH);
            h_cfg_reg    <= SIZE_W'(HEIGHT_CAP);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KERNEL_SIDE:  side_cfg_reg <= cfg_data[SIDE_W-1:0];
                REG_DIVISOR:      div_cfg_reg  <= cfg_data[DIV_W-1:0];
                REG_FRAME_WIDTH:  w_cfg_reg    <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: h_cfg_reg    <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [SIDE_W-1:0] side, side_m1, half;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [DIV_W-1:0]  div_eff;

    assign side    = side_cfg_reg | SIDE_W'(1);
    assign side_m1 = side - SIDE_W'(1);
    assign half    = side >> 1;
    assign div_eff = (div_cfg_reg == '0) ? DIV_W'(1) : div_cfg_reg;
    assign w_eff   = (w_cfg_reg == '0) ? SIZE_W'(1) :
                     (w_cfg_reg > SIZE_W'(MAX_FRAME_WIDTH)) ? SIZE_W'(MAX_FRAME_WIDTH) : w_cfg_reg;
    assign h_eff   = (h_cfg_reg == '0) ? SIZE_W'(1) :
                     (h_cfg_reg > SIZE_W'(HEIGHT_CAP)) ? SIZE_W'(HEIGHT_CAP) : h_cfg_reg;

    // raster position, with row slot kept as row mod MAX_KERNEL_SIDE
    logic [COORD_W-1:0] row_reg, col_reg;
    logic [SLOT_W-1:0]  rslot_reg;
    logic [SIZE_W-1:0]  r0, r1, c0, c1;
    logic [SLOT_W-1:0]  s0, s1;
    logic [COORD_W-1:0] r_reg, c_reg;
    logic [SLOT_W-1:0]  rs_reg;
    logic               pix_acc;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(MAX_KERNEL_SIDE - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    always_comb begin
        r0 = {1'b0, row_reg};
        c0 = {1'b0, col_reg};
        s0 = rslot_reg;
        if (c0 >= w_eff) begin
            c0 = '0;
            r0 = r0 + SIZE_W'(1);
            s0 = slot_inc(s0);
        end
        if (r0 >= h_eff) begin
            r0 = '0;
            s0 = '0;
        end
        r1 = r0;
        s1 = s0;
        c1 = c0 + SIZE_W'(1);
        if (c1 >= w_eff) begin
            c1 = '0;
            r1 = r1 + SIZE_W'(1);
            s1 = slot_inc(s1);
            if (r1 >= h_eff) begin
                r1 = '0;
                s1 = '0;
            end
        end
    end

    assign pix_acc = cmd.accept && (s_kind == REQ_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            rslot_reg <= '0;
        end else if (pix_acc) begin
            row_reg   <= r1[COORD_W-1:0];
            col_reg   <= c1[COORD_W-1:0];
            rslot_reg <= s1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            r_reg  <= r0[COORD_W-1:0];
            c_reg  <= c0[COORD_W-1:0];
            rs_reg <= s0;
        end
    end

    assign st.window_ok = (r_reg >= COORD_W'(side_m1)) && (c_reg >= COORD_W'(side_m1));

    // tap walk counters
    logic [SIDE_W-1:0]  ta_reg, tb_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COORD_W-1:0] col_rd_reg, cbase_reg;
    logic [SLOT_W:0]    start_sum;

    assign start_sum = {1'b0, rs_reg} + (SLOT_W+1)'(MAX_KERNEL_SIDE) - {1'b0, side_m1};
    assign st.last_tap = (ta_reg == side_m1) && (tb_reg == side_m1);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            ta_reg     <= '0;
            tb_reg     <= '0;
            idx_reg    <= '0;
            slot_reg   <= (start_sum >= (SLOT_W+1)'(MAX_KERNEL_SIDE)) ?
                          SLOT_W'(start_sum - (SLOT_W+1)'(MAX_KERNEL_SIDE)) : SLOT_W'(start_sum);
            cbase_reg  <= c_reg - COORD_W'(side_m1);
            col_rd_reg <= c_reg - COORD_W'(side_m1);
        end else if (cmd.tap_issue) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (tb_reg == side_m1) begin
                tb_reg     <= '0;
                ta_reg     <= ta_reg + SIDE_W'(1);
                slot_reg   <= slot_inc(slot_reg);
                col_rd_reg <= cbase_reg;
            end else begin
                tb_reg     <= tb_reg + SIDE_W'(1);
                col_rd_reg <= col_rd_reg + COORD_W'(1);
            end
        end
    end

    // line store
    logic signed [PIX_W-1:0] line_mem [LINE_DEPTH];
    logic signed [PIX_W-1:0] pix_rd_reg;

    always_ff @(posedge aclk) begin
        if (pix_acc) line_mem[{s0, c0[COORD_W-1:0]}] <= pixel_value;
        pix_rd_reg <= line_mem[LA_W'({slot_reg, col_rd_reg})];
    end

    // coefficient store, valid bits give the zero reset
    logic signed [PIX_W-1:0] coef_mem [COEF_COUNT];
    logic [COEF_COUNT-1:0]   coef_vld_reg;
    logic signed [PIX_W-1:0] coef_rd_reg;
    logic                    coef_rd_vld_reg;
    logic                    coef_we;

    assign coef_we = cmd.accept && (s_kind == REQ_COEF) && (coef_index < IDX_W'(COEF_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn)     coef_vld_reg <= '0;
        else if (coef_we) coef_vld_reg[coef_index] <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (coef_we) coef_mem[coef_index] <= coef_value;
        coef_rd_reg     <= coef_mem[idx_reg];
        coef_rd_vld_reg <= coef_vld_reg[idx_reg];
    end

    // multiply-accumulate pipeline
    logic                        v1_reg, v2_reg;
    logic signed [2*PIX_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [PIX_W-1:0]     coef_eff;

    assign coef_eff     = coef_rd_vld_reg ? coef_rd_reg : '0;
    assign st.pipe_busy = v1_reg || v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) prod_reg <= coef_eff * pix_rd_reg;
        if (cmd.setup)   acc_reg <= '0;
        else if (v2_reg) acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // restoring divider on the magnitude, one quotient bit a cycle
    logic [DIV_W-1:0] rem_reg;
    logic [ACC_W-1:0] quo_reg;
    logic [CNT_W-1:0] dcnt_reg;
    logic             neg_reg;
    logic [DIV_W:0]   trial;
    logic             ge;

    assign trial       = {rem_reg, quo_reg[ACC_W-1]};
    assign ge          = trial >= {1'b0, div_eff};
    assign st.div_busy = (dcnt_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= CNT_W'(ACC_W);
        end else if (dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
            neg_reg <= acc_reg[ACC_W-1];
        end else if (dcnt_reg != '0) begin
            rem_reg <= ge ? DIV_W'(trial - {1'b0, div_eff}) : DIV_W'(trial);
            quo_reg <= {quo_reg[ACC_W-2:0], ge};
        end
    end

    // sign restore and saturation
    always_comb begin
        if (neg_reg) begin
            out_value = (quo_reg > ACC_W'(32768)) ? 16'h8000 : PIX_W'(-quo_reg[PIX_W-1:0]);
        end else begin
            out_value = (quo_reg > ACC_W'(32767)) ? 16'h7FFF : quo_reg[PIX_W-1:0];
        end
    end

    // replicated border region and emit counters
    logic [COORD_W-1:0] rhi_reg, clo_reg, chi_reg, er_reg, ec_reg;
    logic [COORD_W-1:0] cr, cc, rlo, clo;

    assign cr  = r_reg - COORD_W'(half);
    assign cc  = c_reg - COORD_W'(half);
    assign rlo = (cr == COORD_W'(half)) ? '0 : cr;
    assign clo = (cc == COORD_W'(half)) ? '0 : cc;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            clo_reg <= clo;
            er_reg  <= rlo;
            ec_reg  <= clo;
            rhi_reg <= ({1'b0, cr} + SIZE_W'(half) + SIZE_W'(1) == h_eff) ?
                       COORD_W'(h_eff - SIZE_W'(1)) : cr;
            chi_reg <= ({1'b0, cc} + SIZE_W'(half) + SIZE_W'(1) == w_eff) ?
                       COORD_W'(w_eff - SIZE_W'(1)) : cc;
        end else if (cmd.emit_adv) begin
            if (ec_reg == chi_reg) begin
                ec_reg <= clo_reg;
                er_reg <= er_reg + COORD_W'(1);
            end else begin
                ec_reg <= ec_reg + COORD_W'(1);
            end
        end
    end

    assign st.emit_last = (er_reg == rhi_reg) && (ec_reg == chi_reg);
    assign out_row      = er_reg;
    assign out_col      = ec_reg;

endmodule

// ===== hw/rtl/image_convolution_edge_replicate_top.sv =====
// top level of the edge-replicating 2-d convolution block
// depends on icer_pkg, icer_ctrl, icer_dp
//
// usage: coefficients and pixels arrive on the s_ stream; s_tuser says which.
// a coefficient beat with an index below 49 is stored and gives no result.
// pixels come in raster order; a pixel that completes a kernel window starts
// a walk of side*side taps through one shared multiply-accumulate fed by the
// line memory and coefficient memory read ports, then a bit-serial divide,
// then one result beat per cycle on m_ while m_tready is high, for the
// window's centre position and, at a frame edge, every border position it
// replicates to, m_tlast on the final one. one item at a time: s_tready is
// high only between items.
// configuration goes over cfg_valid/cfg_index/cfg_data while idle; the user
// must keep to this, the block itself does not enforce it.
// reset (aresetn low, synchronous) restores register defaults, clears the
// raster position and the coefficients; line memory is not cleared.
// a stalled receiver holds the current result beat and the block waits.
module image_convolution_edge_replicate_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [icer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [icer_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // coef_index[5:0], coef_value[21:6], pixel_value[37:22], zero pad
    input  logic [icer_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_row[9:0], out_col[19:10], out_value[35:20], zero pad
    output logic [icer_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);
    import icer_pkg::*;

    icer_cmd_t    cmd;
    icer_status_t st;
    logic [COORD_W-1:0] out_row, out_col;
    logic [PIX_W-1:0]   out_value;

    assign cfg_ready = 1'b1;

    icer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    icer_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_kind      (s_tuser),
        .coef_index  (s_tdata[5:0]),
        .coef_value  (s_tdata[21:6]),
        .pixel_value (s_tdata[37:22]),
        .cmd         (cmd),
        .st          (st),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value)
    );

    // output beat packing
    assign m_tdata = {4'b0000, out_value, out_col, out_row};
    assign m_tlast = st.emit_last;

endmodule
